[sv/ctrd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctrd_pkg
// Types, constants and the window scan step of the CJK text ratio detector.
// ----------------------------------------------------------------------------
package ctrd_pkg;

    localparam int COUNT_WIDTH   = 21;
    localparam int CJK_WIDTH     = 19;
    localparam int PERCENT_WIDTH = 7;
    localparam int STYLE_WIDTH   = 2;
    localparam int ADDR_WIDTH    = 4;
    localparam int DATA_WIDTH    = 32;
    localparam int PRODUCT_WIDTH = COUNT_WIDTH + PERCENT_WIDTH + 1;

    localparam logic [COUNT_WIDTH-1:0]   BYTE_LIMIT_RESET = COUNT_WIDTH'(1048576);
    localparam logic [PERCENT_WIDTH-1:0] THRESHOLD_RESET  = PERCENT_WIDTH'(50);
    localparam logic [PERCENT_WIDTH-1:0] PERCENT_SCALE    = PERCENT_WIDTH'(100);

    localparam logic [7:0] CH_QUOTE_DOUBLE = 8'h22;
    localparam logic [7:0] CH_QUOTE_SINGLE = 8'h27;
    localparam logic [7:0] CH_BACKSLASH    = 8'h5C;
    localparam logic [7:0] CH_SLASH        = 8'h2F;
    localparam logic [7:0] CH_STAR         = 8'h2A;
    localparam logic [7:0] CH_HASH         = 8'h23;
    localparam logic [7:0] CH_LESS         = 8'h3C;
    localparam logic [7:0] CH_BANG         = 8'h21;
    localparam logic [7:0] CH_DASH         = 8'h2D;
    localparam logic [7:0] CH_GREATER      = 8'h3E;
    localparam logic [7:0] CJK_LEAD_LO     = 8'hE4;
    localparam logic [7:0] CJK_LEAD_HI     = 8'hE9;
    localparam logic [7:0] CJK_SECOND_LO   = 8'hBA;
    localparam logic [7:0] CONT_LO         = 8'h80;
    localparam logic [7:0] CONT_HI         = 8'hBF;
    localparam logic [7:0] LEAD2_MASK      = 8'hE0;
    localparam logic [7:0] LEAD2_CODE      = 8'hC0;
    localparam logic [7:0] LEAD3_MASK      = 8'hF0;
    localparam logic [7:0] LEAD3_CODE      = 8'hE0;

    typedef enum logic [1:0] {
        REG_COMMENT_STYLE     = 2'd0,
        REG_BYTE_LIMIT        = 2'd1,
        REG_PERCENT_THRESHOLD = 2'd2
    } reg_index_t;

    typedef enum logic [STYLE_WIDTH-1:0] {
        STYLE_NONE = 2'd0,
        STYLE_C    = 2'd1,
        STYLE_HASH = 2'd2,
        STYLE_HTML = 2'd3
    } style_t;

    typedef enum logic [2:0] {
        MODE_CODE   = 3'd0,
        MODE_STRING = 3'd1,
        MODE_BLOCK  = 3'd2,
        MODE_LINE   = 3'd3,
        MODE_HTML   = 3'd4
    } scan_mode_t;

    // state kept between requests
    typedef struct packed {
        scan_mode_t             mode;
        logic                   quote_single;
        logic                   prev_bs;
        logic [1:0]             skip;
        logic [1:0]             html_prog;
        logic                   limit_hit;
        logic [CJK_WIDTH-1:0]   cjk;
        logic [COUNT_WIDTH-1:0] bytes;
        logic [2:0][7:0]        q;
        logic [1:0]             len;
    } scan_t;

    // working copy with room for the incoming byte
    typedef struct packed {
        scan_mode_t             mode;
        logic                   quote_single;
        logic                   prev_bs;
        logic [1:0]             skip;
        logic [1:0]             html_prog;
        logic                   limit_hit;
        logic [CJK_WIDTH-1:0]   cjk;
        logic [COUNT_WIDTH-1:0] bytes;
        logic [3:0][7:0]        q;
        logic [2:0]             len;
    } work_t;

    function automatic work_t to_work(input scan_t s);
        work_t w;
        w.mode         = s.mode;
        w.quote_single = s.quote_single;
        w.prev_bs      = s.prev_bs;
        w.skip         = s.skip;
        w.html_prog    = s.html_prog;
        w.limit_hit    = s.limit_hit;
        w.cjk          = s.cjk;
        w.bytes        = s.bytes;
        w.q            = {8'h00, s.q};
        w.len          = {1'b0, s.len};
        return w;
    endfunction

    function automatic scan_t to_scan(input work_t w);
        scan_t s;
        s.mode         = w.mode;
        s.quote_single = w.quote_single;
        s.prev_bs      = w.prev_bs;
        s.skip         = w.skip;
        s.html_prog    = w.html_prog;
        s.limit_hit    = w.limit_hit;
        s.cjk          = w.cjk;
        s.bytes        = w.bytes;
        s.q            = w.q[2:0];
        s.len          = w.len[1:0];
        return s;
    endfunction

    function automatic scan_t scan_clear();
        scan_t s;
        s.mode         = MODE_CODE;
        s.quote_single = 1'b0;
        s.prev_bs      = 1'b0;
        s.skip         = 2'd0;
        s.html_prog    = 2'd0;
        s.limit_hit    = 1'b0;
        s.cjk          = '0;
        s.bytes        = '0;
        s.q            = '0;
        s.len          = 2'd0;
        return s;
    endfunction

    // one element at the head of a non-empty window
    function automatic work_t scan_head(input work_t s, input style_t style,
                                        input logic [COUNT_WIDTH-1:0] limit);
        work_t                r;
        logic [7:0]           c;
        logic [7:0]           c1;
        logic [7:0]           c2;
        logic [7:0]           c3;
        logic [7:0]           quote;
        logic [2:0]           k;
        logic [2:0]           add;
        logic [2:0]           seq;
        logic                 cjk_hit;
        logic                 cjk_ok;
        logic                 plain;
        logic [COUNT_WIDTH:0] sum;
        r       = s;
        k       = 3'd1;
        add     = 3'd0;
        cjk_hit = 1'b0;
        plain   = 1'b0;
        c       = s.q[0];
        c1      = (s.len > 3'd1) ? s.q[1] : 8'h00;
        c2      = (s.len > 3'd2) ? s.q[2] : 8'h00;
        c3      = (s.len > 3'd3) ? s.q[3] : 8'h00;
        quote   = s.quote_single ? CH_QUOTE_SINGLE : CH_QUOTE_DOUBLE;
        if ((c & LEAD2_MASK) == LEAD2_CODE) begin
            seq = 3'd2;
        end else if ((c & LEAD3_MASK) == LEAD3_CODE) begin
            seq = 3'd3;
        end else begin
            seq = 3'd4;
        end
        cjk_ok = (s.len > 3'd2) && (c >= CJK_LEAD_LO) && (c <= CJK_LEAD_HI)
                 && ((c != CJK_LEAD_LO) || (c1 >= CJK_SECOND_LO))
                 && (c1 >= CONT_LO) && (c1 <= CONT_HI)
                 && (c2 >= CONT_LO) && (c2 <= CONT_HI);

        if (s.skip != 2'd0) begin
            r.skip = s.skip - 2'd1;
        end else if (s.mode == MODE_LINE) begin
            r.mode = MODE_LINE;
        end else if (s.mode == MODE_HTML) begin
            if (c == CH_DASH) begin
                r.html_prog = (s.html_prog != 2'd0) ? 2'd2 : 2'd1;
            end else if (c == CH_GREATER && s.html_prog == 2'd2) begin
                r.mode      = MODE_CODE;
                r.html_prog = 2'd0;
            end else begin
                r.html_prog = 2'd0;
            end
        end else if (s.limit_hit || s.bytes >= limit) begin
            r.limit_hit = 1'b1;
        end else if (s.mode == MODE_STRING) begin
            if (c == quote && !s.prev_bs) begin
                r.mode         = MODE_CODE;
                r.quote_single = 1'b0;
                add            = 3'd1;
            end else begin
                plain = 1'b1;
            end
        end else if (s.mode == MODE_BLOCK) begin
            if (s.len > 3'd1 && c == CH_STAR && c1 == CH_SLASH) begin
                r.mode = MODE_CODE;
                add    = 3'd2;
                k      = 3'd2;
            end else begin
                plain = 1'b1;
            end
        end else if ((c == CH_QUOTE_DOUBLE || c == CH_QUOTE_SINGLE) && !s.prev_bs) begin
            r.mode         = MODE_STRING;
            r.quote_single = (c == CH_QUOTE_SINGLE);
            add            = 3'd1;
        end else if (style == STYLE_C && s.len > 3'd1 && c == CH_SLASH && c1 == CH_SLASH) begin
            r.mode = MODE_LINE;
        end else if (style == STYLE_C && s.len > 3'd1 && c == CH_SLASH && c1 == CH_STAR) begin
            r.mode = MODE_BLOCK;
            add    = 3'd2;
            k      = 3'd2;
        end else if (style == STYLE_HASH && c == CH_HASH) begin
            r.mode = MODE_LINE;
        end else if (style == STYLE_HTML && s.len > 3'd3 && c == CH_LESS && c1 == CH_BANG
                     && c2 == CH_DASH && c3 == CH_DASH) begin
            r.mode      = MODE_HTML;
            r.html_prog = 2'd0;
            k           = 3'd4;
        end else if (cjk_ok) begin
            cjk_hit = 1'b1;
            add     = 3'd3;
            k       = 3'd3;
        end else begin
            plain = 1'b1;
        end

        if (plain) begin
            if (c < CONT_LO) begin
                add = 3'd1;
            end else begin
                add    = seq;
                r.skip = 2'(seq - 3'd1);
            end
        end

        sum     = {1'b0, s.bytes} + (COUNT_WIDTH + 1)'(add);
        r.bytes = sum[COUNT_WIDTH] ? '1 : sum[COUNT_WIDTH-1:0];
        if (cjk_hit && s.cjk != '1) begin
            r.cjk = s.cjk + CJK_WIDTH'(1);
        end

        case (k)
            3'd1:    r.prev_bs = (s.q[0] == CH_BACKSLASH);
            3'd2:    r.prev_bs = (s.q[1] == CH_BACKSLASH);
            3'd3:    r.prev_bs = (s.q[2] == CH_BACKSLASH);
            default: r.prev_bs = (s.q[3] == CH_BACKSLASH);
        endcase
        r.q   = s.q >> (8 * k);
        r.len = s.len - k;
        return r;
    endfunction

endpackage

[sv/cjk_text_ratio_detector.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cjk_text_ratio_detector
// Scans UTF-8 text for its share of CJK characters in code outside strings
// and comments, and gives a verdict with the counts at each text end.
// ----------------------------------------------------------------------------
// Usage:
//   s_* channel takes one request per byte: s_text_byte with s_line_end on the
//   last byte of a line, s_text_end to close the text (s_no_byte set when the
//   request carries only the marks). A request is taken at every cycle that
//   s_valid and s_ready are high, one per cycle sustained unless s_ready drops.
//   m_* channel gives one result per text end: m_is_chinese, m_cjk_count and
//   m_byte_count. m_valid rises once the closing request has been taken and its
//   result has moved from the compare stage into the output register: the scan
//   state updates in the accept cycle, the percentage compare (two multiplies)
//   runs in the following stage into the output register.
//   Up to three bytes of a line wait in a lookahead window; the line end
//   or the text end flushes them within the same cycle.
//   When m_ready is low the result stays in the output register, one more
//   result can wait in the compare stage, and s_ready drops only when both
//   are full, for every request whatever it carries.
//   Reset clears scan state and counters and sets comment style to none, byte
//   limit to 1048576 and threshold to 50. Registers sit on the APB port at
//   byte addresses 0, 4 and 8 and should be written only while idle.
// ----------------------------------------------------------------------------
module cjk_text_ratio_detector
    import ctrd_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,

    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [ADDR_WIDTH-1:0]    paddr,
    input  logic [DATA_WIDTH-1:0]    pwdata,
    output logic [DATA_WIDTH-1:0]    prdata,
    output logic                     pready,

    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [7:0]               s_text_byte,
    input  logic                     s_line_end,
    input  logic                     s_text_end,
    input  logic                     s_no_byte,

    output logic                     m_valid,
    input  logic                     m_ready,
    output logic                     m_is_chinese,
    output logic [CJK_WIDTH-1:0]     m_cjk_count,
    output logic [COUNT_WIDTH-1:0]   m_byte_count
);

    style_t                   comment_style_reg;
    logic [COUNT_WIDTH-1:0]   byte_limit_reg;
    logic [PERCENT_WIDTH-1:0] percent_threshold_reg;

    scan_t                    scan_reg;
    scan_t                    scan_next;

    logic                     p1_valid_reg;
    logic [CJK_WIDTH-1:0]     p1_cjk_reg;
    logic [COUNT_WIDTH-1:0]   p1_bytes_reg;
    logic [PERCENT_WIDTH-1:0] p1_thr_reg;

    logic                     m_valid_reg;
    logic                     m_is_chinese_reg;
    logic [CJK_WIDTH-1:0]     m_cjk_count_reg;
    logic [COUNT_WIDTH-1:0]   m_byte_count_reg;

    logic                     cfg_write;
    reg_index_t               cfg_index;
    logic                     accept;
    logic                     out_free;
    logic                     p1_free;
    work_t                    work;
    logic [PERCENT_WIDTH:0]   thr_plus;
    logic [PRODUCT_WIDTH-1:0] lhs;
    logic [PRODUCT_WIDTH-1:0] rhs;
    logic                     verdict;

    // configuration port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_index = reg_index_t'(paddr[ADDR_WIDTH-1:2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            comment_style_reg     <= STYLE_NONE;
            byte_limit_reg        <= BYTE_LIMIT_RESET;
            percent_threshold_reg <= THRESHOLD_RESET;
        end else if (cfg_write) begin
            unique case (cfg_index)
                REG_COMMENT_STYLE:     comment_style_reg     <= style_t'(pwdata[STYLE_WIDTH-1:0]);
                REG_BYTE_LIMIT:        byte_limit_reg        <= pwdata[COUNT_WIDTH-1:0];
                REG_PERCENT_THRESHOLD: percent_threshold_reg <= pwdata[PERCENT_WIDTH-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_index)
            REG_COMMENT_STYLE:     prdata = DATA_WIDTH'(comment_style_reg);
            REG_BYTE_LIMIT:        prdata = DATA_WIDTH'(byte_limit_reg);
            REG_PERCENT_THRESHOLD: prdata = DATA_WIDTH'(percent_threshold_reg);
            default:               prdata = '0;
        endcase
    end

    // handshake
    assign out_free = !m_valid_reg || m_ready;
    assign p1_free  = !p1_valid_reg || out_free;
    assign s_ready  = p1_free;
    assign accept   = s_valid && s_ready;

    // scan step: push the byte unless s_no_byte, then flush the window on a line or text end
    always_comb begin
        work = to_work(scan_reg);
        if (!s_no_byte) begin
            work.q[work.len[1:0]] = s_text_byte;
            work.len              = work.len + 3'd1;
            if (work.len == 3'd4) begin
                work = scan_head(work, comment_style_reg, byte_limit_reg);
            end
        end
        if (s_line_end || s_text_end) begin
            for (int i = 0; i < 3; i++) begin
                if (work.len != 3'd0) begin
                    work = scan_head(work, comment_style_reg, byte_limit_reg);
                end
            end
            work.prev_bs   = 1'b0;
            work.skip      = 2'd0;
            work.html_prog = 2'd0;
            if (work.mode == MODE_LINE || work.mode == MODE_HTML) begin
                work.mode = MODE_CODE;
            end
        end
        scan_next = s_text_end ? scan_clear() : to_scan(work);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scan_reg <= scan_clear();
        end else if (accept) begin
            scan_reg <= scan_next;
        end
    end

    // compare stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
        end else if (accept && s_text_end) begin
            p1_valid_reg <= 1'b1;
        end else if (out_free) begin
            p1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && s_text_end) begin
            p1_cjk_reg   <= work.cjk;
            p1_bytes_reg <= work.bytes;
            p1_thr_reg   <= percent_threshold_reg;
        end
    end

    assign thr_plus = {1'b0, p1_thr_reg} + (PERCENT_WIDTH + 1)'(1);
    assign lhs      = PRODUCT_WIDTH'(p1_cjk_reg) * PRODUCT_WIDTH'(PERCENT_SCALE);
    assign rhs      = PRODUCT_WIDTH'(thr_plus) * PRODUCT_WIDTH'(p1_bytes_reg);
    assign verdict  = (p1_bytes_reg != '0) && (lhs >= rhs);

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_free) begin
            m_valid_reg <= p1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free && p1_valid_reg) begin
            m_is_chinese_reg <= verdict;
            m_cjk_count_reg  <= p1_cjk_reg;
            m_byte_count_reg <= p1_bytes_reg;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_is_chinese = m_is_chinese_reg;
    assign m_cjk_count  = m_cjk_count_reg;
    assign m_byte_count = m_byte_count_reg;

`ifndef SYNTHESIS
    a_text_end_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && s_text_end |=> scan_reg.len == 2'd0 && scan_reg.bytes == '0
                                 && scan_reg.cjk == '0 && !scan_reg.limit_hit)
        else $error("scan state not cleared after text end");

    a_line_end_flushes: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && s_line_end |=> scan_reg.len == 2'd0 && !scan_reg.prev_bs
                                 && scan_reg.skip == 2'd0 && scan_reg.mode != MODE_LINE
                                 && scan_reg.mode != MODE_HTML)
        else $error("lookahead window not flushed at line end");

    a_stage_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        p1_valid_reg && !out_free |=> p1_valid_reg && $stable(p1_bytes_reg)
                                      && $stable(p1_cjk_reg))
        else $error("compare stage lost a result under stall");

    a_verdict_needs_bytes: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_is_chinese_reg |-> m_byte_count_reg != '0)
        else $error("positive verdict on empty text");

    a_no_accept_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        p1_valid_reg && m_valid_reg && !m_ready |-> !s_ready)
        else $error("request taken while both result stages are full");
`endif

endmodule
